[src/sip_pkg.sv]
package sip_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 64;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // what travels with an item besides the division operands
  typedef struct packed {
    logic signed [COORD_W-1:0] base_ax;
    logic signed [COORD_W-1:0] base_az;
    logic signed [COORD_W-1:0] base_bx;
    logic signed [COORD_W-1:0] base_bz;
    logic signed [DIFF_W-1:0]  d_ax;
    logic signed [DIFF_W-1:0]  d_az;
    logic signed [DIFF_W-1:0]  d_bx;
    logic signed [DIFF_W-1:0]  d_bz;
  } carry_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              hit;
    logic [PROD_W-1:0] dm;
    logic [PROD_W-1:0] n1m;
    logic [PROD_W-1:0] n2m;
    carry_t            c;
  } item_t;

endpackage

[src/segment_intersection_point.sv]
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// input    | in_valid, in_ready, in_a_*, in_b_*      | in
// result   | out_valid, out_ready, out_hit, out_cross_* | out
//
// one segment pair per cycle sustained when nothing stalls; the path is
// 4 front stages, the queue, then FRAC_BITS divider stages plus 3 more
// to the output register; the front holds only when its 4-entry queue
// is full, the back only when the output register is full and not being
// taken; the FRAC_BITS-stage restoring divider is fully pipelined
// rst_n clears valid bits and queue pointers; data registers are not reset
module segment_intersection_point
  import sip_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_a_start_x,
  input  logic signed [COORD_W-1:0] in_a_start_z,
  input  logic signed [COORD_W-1:0] in_a_end_x,
  input  logic signed [COORD_W-1:0] in_a_end_z,
  input  logic signed [COORD_W-1:0] in_b_start_x,
  input  logic signed [COORD_W-1:0] in_b_start_z,
  input  logic signed [COORD_W-1:0] in_b_end_x,
  input  logic signed [COORD_W-1:0] in_b_end_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_hit,
  output logic signed [COORD_W-1:0] out_cross_a_x,
  output logic signed [COORD_W-1:0] out_cross_a_z,
  output logic signed [COORD_W-1:0] out_cross_b_x,
  output logic signed [COORD_W-1:0] out_cross_b_z
);

  logic  q_full, q_push, q_pop, q_not_empty;
  item_t q_in, q_out;

  // classify front
  sip_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a_start_x (in_a_start_x),
    .in_a_start_z (in_a_start_z),
    .in_a_end_x   (in_a_end_x),
    .in_a_end_z   (in_a_end_z),
    .in_b_start_x (in_b_start_x),
    .in_b_start_z (in_b_start_z),
    .in_b_end_x   (in_b_end_x),
    .in_b_end_z   (in_b_end_z),
    .q_full       (q_full),
    .push         (q_push),
    .push_item    (q_in)
  );

  // decoupling queue
  sip_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out)
  );

  // divide and interpolate back
  sip_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_item        (q_out),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_cross_a_x (out_cross_a_x),
    .out_cross_a_z (out_cross_a_z),
    .out_cross_b_x (out_cross_b_x),
    .out_cross_b_z (out_cross_b_z)
  );

endmodule

[src/sip_front.sv]
module sip_front
  import sip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_a_start_x,
  input  logic signed [COORD_W-1:0] in_a_start_z,
  input  logic signed [COORD_W-1:0] in_a_end_x,
  input  logic signed [COORD_W-1:0] in_a_end_z,
  input  logic signed [COORD_W-1:0] in_b_start_x,
  input  logic signed [COORD_W-1:0] in_b_start_z,
  input  logic signed [COORD_W-1:0] in_b_end_x,
  input  logic signed [COORD_W-1:0] in_b_end_z,
  input  logic                      q_full,
  output logic                      push,
  output item_t                     push_item
);

  logic en;
  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [COORD_W-1:0] x1_r, z1_r, x3_r, z3_r;
  logic signed [DIFF_W-1:0]  dx43_r, dz12_r, dx21_r, dz43_r, dx13_r, dz13_r;
  logic signed [DIFF_W-1:0]  dx12, dz34;
  logic signed [2*DIFF_W-1:0] m0, m1, m2, m3, m4, m5;
  logic [PROD_W-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic [PROD_W-1:0] den_r, n1_r, n2_r;
  logic [PROD_W-1:0] dm_r, n1m_r, n2m_r;
  logic              ok_r;
  carry_t            c2_nxt, c2_r, c3_r, c4_r;

  // whole front advances while the queue has room
  assign en       = !q_full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // stage 1: coordinate differences, exact in 33 bits
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= in_a_start_x;
      z1_r   <= in_a_start_z;
      x3_r   <= in_b_start_x;
      z3_r   <= in_b_start_z;
      dx43_r <= DIFF_W'(in_b_end_x) - DIFF_W'(in_b_start_x);
      dz12_r <= DIFF_W'(in_a_start_z) - DIFF_W'(in_a_end_z);
      dx21_r <= DIFF_W'(in_a_end_x) - DIFF_W'(in_a_start_x);
      dz43_r <= DIFF_W'(in_b_end_z) - DIFF_W'(in_b_start_z);
      dx13_r <= DIFF_W'(in_a_start_x) - DIFF_W'(in_b_start_x);
      dz13_r <= DIFF_W'(in_a_start_z) - DIFF_W'(in_b_start_z);
    end
  end

  // stage 2: six cross products, kept modulo 2^64
  always_comb begin
    dx12 = -dx21_r;
    dz34 = -dz43_r;
    m0   = dx43_r * dz12_r;
    m1   = dx12 * dz43_r;
    m2   = dz34 * dx13_r;
    m3   = dx43_r * dz13_r;
    m4   = dz12_r * dx13_r;
    m5   = dx21_r * dz13_r;
    c2_nxt.base_ax = x1_r;
    c2_nxt.base_az = z1_r;
    c2_nxt.base_bx = x3_r;
    c2_nxt.base_bz = z3_r;
    c2_nxt.d_ax    = dx21_r;
    c2_nxt.d_az    = -dz12_r;
    c2_nxt.d_bx    = dx43_r;
    c2_nxt.d_bz    = dz43_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= m0[PROD_W-1:0];
      p1_r <= m1[PROD_W-1:0];
      p2_r <= m2[PROD_W-1:0];
      p3_r <= m3[PROD_W-1:0];
      p4_r <= m4[PROD_W-1:0];
      p5_r <= m5[PROD_W-1:0];
      c2_r <= c2_nxt;
    end
  end

  // stage 3: denominator and numerators
  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= p0_r - p1_r;
      n1_r  <= p2_r + p3_r;
      n2_r  <= p4_r + p5_r;
      c3_r  <= c2_r;
    end
  end

  // stage 4: magnitudes and sign agreement
  always_ff @(posedge clk) begin
    if (en) begin
      dm_r  <= den_r[PROD_W-1] ? (~den_r + 1'b1) : den_r;
      n1m_r <= n1_r[PROD_W-1] ? (~n1_r + 1'b1) : n1_r;
      n2m_r <= n2_r[PROD_W-1] ? (~n2_r + 1'b1) : n2_r;
      ok_r  <= (den_r != '0) && (n1_r != '0) && (n2_r != '0) &&
               (n1_r[PROD_W-1] == den_r[PROD_W-1]) &&
               (n2_r[PROD_W-1] == den_r[PROD_W-1]);
      c4_r  <= c3_r;
    end
  end

  // strict interior test, then transfer into the queue
  always_comb begin
    push_item.hit = ok_r && (n1m_r < dm_r) && (n2m_r < dm_r);
    push_item.dm  = dm_r;
    push_item.n1m = n1m_r;
    push_item.n2m = n2m_r;
    push_item.c   = c4_r;
  end

  assign push = v4_r && en;

endmodule

[src/sip_queue.sv]
module sip_queue
  import sip_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;
  logic            do_pop;

  assign full      = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

[src/sip_back.sv]
module sip_back
  import sip_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  input  item_t                     q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_hit,
  output logic signed [COORD_W-1:0] out_cross_a_x,
  output logic signed [COORD_W-1:0] out_cross_a_z,
  output logic signed [COORD_W-1:0] out_cross_b_x,
  output logic signed [COORD_W-1:0] out_cross_b_z
);

  localparam int PW = DIFF_W + FRAC_BITS + 1;
  localparam int SW = DIFF_W + 2;

  logic en;

  logic                 v_r   [FRAC_BITS+1];
  logic                 hit_r [FRAC_BITS+1];
  logic [PROD_W-1:0]    dm_r  [FRAC_BITS+1];
  logic [PROD_W-1:0]    r1_r  [FRAC_BITS+1];
  logic [PROD_W-1:0]    r2_r  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q1_r  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q2_r  [FRAC_BITS+1];
  carry_t               c_r   [FRAC_BITS+1];

  logic                      vm_r, hm_r, out_valid_r;
  logic signed [PW-1:0]      pax, paz, pbx, pbz;
  logic signed [PW-1:0]      pax_r, paz_r, pbx_r, pbz_r;
  logic signed [COORD_W-1:0] bax_r, baz_r, bbx_r, bbz_r;

  // back pipeline moves whenever the output register can take a result
  assign en        = !out_valid_r || out_ready;
  assign q_pop     = q_not_empty && en;
  assign out_valid = out_valid_r;

  // floor shift, rebase and clamp to the coordinate range
  function automatic logic signed [COORD_W-1:0] fin(input logic signed [PW-1:0] p,
                                                    input logic signed [COORD_W-1:0] b);
    logic signed [PW-1:0] sh;
    logic signed [SW-1:0] s;
    sh = p >>> FRAC_BITS;
    s  = SW'(sh) + SW'(b);
    if ((s[SW-1:COORD_W-1] == '0) || (s[SW-1:COORD_W-1] == '1)) begin
      return s[COORD_W-1:0];
    end else if (s[SW-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // valid bits of all back stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= FRAC_BITS; k++) begin
        v_r[k] <= 1'b0;
      end
      vm_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_not_empty;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        v_r[k] <= v_r[k-1];
      end
      vm_r        <= v_r[FRAC_BITS];
      out_valid_r <= vm_r;
    end
  end

  // entry stage: operands off the queue
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r[0] <= q_item.hit;
      dm_r[0]  <= q_item.dm;
      r1_r[0]  <= q_item.n1m;
      r2_r[0]  <= q_item.n2m;
      q1_r[0]  <= '0;
      q2_r[0]  <= '0;
      c_r[0]   <= q_item.c;
    end
  end

  // restoring divider, one quotient bit per stage for both parameters
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    logic [PROD_W:0]   s1, s2;
    logic              ge1, ge2;
    logic [PROD_W-1:0] rn1, rn2;

    always_comb begin
      s1  = {r1_r[k], 1'b0};
      s2  = {r2_r[k], 1'b0};
      ge1 = s1 >= {1'b0, dm_r[k]};
      ge2 = s2 >= {1'b0, dm_r[k]};
      rn1 = ge1 ? PROD_W'(s1 - {1'b0, dm_r[k]}) : s1[PROD_W-1:0];
      rn2 = ge2 ? PROD_W'(s2 - {1'b0, dm_r[k]}) : s2[PROD_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hit_r[k+1] <= hit_r[k];
        dm_r[k+1]  <= dm_r[k];
        r1_r[k+1]  <= rn1;
        r2_r[k+1]  <= rn2;
        q1_r[k+1]  <= {q1_r[k][FRAC_BITS-2:0], ge1};
        q2_r[k+1]  <= {q2_r[k][FRAC_BITS-2:0], ge2};
        c_r[k+1]   <= c_r[k];
      end
    end
  end

  // interpolation products, delta times parameter
  always_comb begin
    pax = c_r[FRAC_BITS].d_ax * $signed({1'b0, q1_r[FRAC_BITS]});
    paz = c_r[FRAC_BITS].d_az * $signed({1'b0, q1_r[FRAC_BITS]});
    pbx = c_r[FRAC_BITS].d_bx * $signed({1'b0, q2_r[FRAC_BITS]});
    pbz = c_r[FRAC_BITS].d_bz * $signed({1'b0, q2_r[FRAC_BITS]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pax_r <= pax;
      paz_r <= paz;
      pbx_r <= pbx;
      pbz_r <= pbz;
      hm_r  <= hit_r[FRAC_BITS];
      bax_r <= c_r[FRAC_BITS].base_ax;
      baz_r <= c_r[FRAC_BITS].base_az;
      bbx_r <= c_r[FRAC_BITS].base_bx;
      bbz_r <= c_r[FRAC_BITS].base_bz;
    end
  end

  // output register, points zeroed on a miss
  always_ff @(posedge clk) begin
    if (en) begin
      out_hit       <= hm_r;
      out_cross_a_x <= hm_r ? fin(pax_r, bax_r) : '0;
      out_cross_a_z <= hm_r ? fin(paz_r, baz_r) : '0;
      out_cross_b_x <= hm_r ? fin(pbx_r, bbx_r) : '0;
      out_cross_b_z <= hm_r ? fin(pbz_r, bbz_r) : '0;
    end
  end

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit) |-> ((out_cross_a_x == '0) && (out_cross_a_z == '0) &&
                                   (out_cross_b_x == '0) && (out_cross_b_z == '0)))
    else $error("miss carries nonzero point");
  a_hit_den: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && hit_r[0]) |-> ((dm_r[0] != '0) && (r1_r[0] < dm_r[0]) &&
                              (r2_r[0] < dm_r[0])))
    else $error("hit with parameter outside the unit interval");
`endif

endmodule
